[design/iest_pkg.sv]
`default_nettype none
package iest_pkg;

	localparam int NUM_KEYS_DEF    = 512;
	localparam int NUM_BUTTONS_DEF = 8;

	localparam int KEY_CODE_W = 10;
	localparam int BTN_CODE_W = 4;
	localparam int KEY_ROW_W  = 32;
	localparam int KEY_BIT_W  = 5;

	localparam logic [3:0] ACT_KEY_DOWN   = 4'd0;
	localparam logic [3:0] ACT_KEY_UP     = 4'd1;
	localparam logic [3:0] ACT_BTN_DOWN   = 4'd2;
	localparam logic [3:0] ACT_BTN_UP     = 4'd3;
	localparam logic [3:0] ACT_MOVE       = 4'd4;
	localparam logic [3:0] ACT_WHEEL      = 4'd5;
	localparam logic [3:0] ACT_FOCUS_LOST = 4'd6;
	localparam logic [3:0] ACT_NEW_FRAME  = 4'd7;

	typedef struct packed {
		logic capture;
		logic exec;
	} iest_cmd_t;

endpackage
`default_nettype wire

[design/iest_ram.sv]
`default_nettype none
module iest_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                                    clk,
	input  logic                                    we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                        wdata,
	input  logic                                    re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                        rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

[design/iest_ctrl.sv]
`default_nettype none
module iest_ctrl
	import iest_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      start,
	output logic      busy,
	output logic      done,
	output iest_cmd_t cmd
);

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

	state_t state_q;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					done_q <= 1'b0;
					if (start) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					done_q  <= 1'b1;
					state_q <= ST_IDLE;
				end
				default: begin
					done_q  <= 1'b0;
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy        = (state_q == ST_EXEC);
	assign done        = done_q;
	assign cmd.capture = (state_q == ST_IDLE) && start;
	assign cmd.exec    = (state_q == ST_EXEC);

endmodule
`default_nettype wire

[design/iest_dp.sv]
`default_nettype none
module iest_dp
	import iest_pkg::*;
#(
	parameter int NUM_KEYS    = NUM_KEYS_DEF,
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  iest_cmd_t             cmd,
	input  logic [3:0]            action,
	input  logic [KEY_CODE_W-1:0] key_code,
	input  logic                  is_repeat,
	input  logic [BTN_CODE_W-1:0] button_code,
	input  logic signed [15:0]    pointer_x,
	input  logic signed [15:0]    pointer_y,
	input  logic signed [15:0]    move_dx,
	input  logic signed [15:0]    move_dy,
	input  logic signed [15:0]    wheel_dx,
	input  logic signed [15:0]    wheel_dy,
	output logic                  key_is_down,
	output logic                  key_was_pressed,
	output logic                  key_was_released,
	output logic                  button_is_down,
	output logic                  button_was_pressed,
	output logic                  button_was_released,
	output logic signed [15:0]    mouse_x,
	output logic signed [15:0]    mouse_y,
	output logic signed [31:0]    motion_x,
	output logic signed [31:0]    motion_y,
	output logic signed [31:0]    wheel_total_x,
	output logic signed [31:0]    wheel_total_y
);

	localparam int KEY_ROWS = (NUM_KEYS + KEY_ROW_W - 1) / KEY_ROW_W;
	localparam int ROW_AW   = KEY_ROWS > 1 ? $clog2(KEY_ROWS) : 1;
	localparam int BTN_AW   = NUM_BUTTONS > 1 ? $clog2(NUM_BUTTONS) : 1;
	localparam int RAM_W    = 3 * KEY_ROW_W;

	// latched word
	logic [3:0]            act_q;
	logic [KEY_CODE_W-1:0] key_q;
	logic                  rep_q;
	logic [BTN_CODE_W-1:0] btn_q;
	logic signed [15:0]    px_q;
	logic signed [15:0]    py_q;
	logic signed [15:0]    mdx_q;
	logic signed [15:0]    mdy_q;
	logic signed [15:0]    wdx_q;
	logic signed [15:0]    wdy_q;

	// state
	logic [KEY_ROWS-1:0]    held_vld_q;
	logic [KEY_ROWS-1:0]    mark_vld_q;
	logic [NUM_BUTTONS-1:0] bheld_q;
	logic [NUM_BUTTONS-1:0] bpress_q;
	logic [NUM_BUTTONS-1:0] brel_q;
	logic signed [15:0]     pos_x_q;
	logic signed [15:0]     pos_y_q;
	logic signed [31:0]     mot_x_q;
	logic signed [31:0]     mot_y_q;
	logic signed [31:0]     whl_x_q;
	logic signed [31:0]     whl_y_q;

	logic [5:0] flags_q;

	logic [ROW_AW-1:0]    rd_row;
	logic [ROW_AW-1:0]    row_idx;
	logic [KEY_BIT_W-1:0] bit_idx;
	logic [BTN_AW-1:0]    btn_idx;
	logic                 kok;
	logic                 bok;
	logic [RAM_W-1:0]     rdata;
	logic [RAM_W-1:0]     wdata;
	logic                 we;
	logic [KEY_ROW_W-1:0] held_row;
	logic [KEY_ROW_W-1:0] press_row;
	logic [KEY_ROW_W-1:0] rel_row;
	logic [KEY_ROW_W-1:0] held_n;
	logic [KEY_ROW_W-1:0] press_n;
	logic [KEY_ROW_W-1:0] rel_n;
	logic [NUM_BUTTONS-1:0] bheld_n;
	logic [NUM_BUTTONS-1:0] bpress_n;
	logic [NUM_BUTTONS-1:0] brel_n;

	assign rd_row  = ROW_AW'(key_code >> KEY_BIT_W);
	assign row_idx = ROW_AW'(key_q >> KEY_BIT_W);
	assign bit_idx = key_q[KEY_BIT_W-1:0];
	assign btn_idx = BTN_AW'(btn_q);
	assign kok     = {1'b0, key_q} < (KEY_CODE_W + 1)'(NUM_KEYS);
	assign bok     = {1'b0, btn_q} < (BTN_CODE_W + 1)'(NUM_BUTTONS);

	iest_ram #(
		.WIDTH(RAM_W),
		.DEPTH(KEY_ROWS)
	) u_key_ram (
		.clk  (clk),
		.we   (we),
		.waddr(row_idx),
		.wdata(wdata),
		.re   (cmd.capture),
		.raddr(rd_row),
		.rdata(rdata)
	);

	// rows not written since the last clear read as zero
	always_comb begin
		held_row  = held_vld_q[row_idx] ? rdata[KEY_ROW_W-1:0] : '0;
		press_row = mark_vld_q[row_idx] ? rdata[2*KEY_ROW_W-1:KEY_ROW_W] : '0;
		rel_row   = mark_vld_q[row_idx] ? rdata[3*KEY_ROW_W-1:2*KEY_ROW_W] : '0;
		held_n    = held_row;
		press_n   = press_row;
		rel_n     = rel_row;
		bheld_n   = bheld_q;
		bpress_n  = bpress_q;
		brel_n    = brel_q;
		unique case (act_q)
			ACT_KEY_DOWN: begin
				held_n[bit_idx] = 1'b1;
				if (!rep_q) begin
					press_n[bit_idx] = 1'b1;
				end
			end
			ACT_KEY_UP: begin
				held_n[bit_idx] = 1'b0;
				rel_n[bit_idx]  = 1'b1;
			end
			ACT_BTN_DOWN: begin
				if (bok) begin
					bheld_n[btn_idx]  = 1'b1;
					bpress_n[btn_idx] = 1'b1;
				end
			end
			ACT_BTN_UP: begin
				if (bok) begin
					bheld_n[btn_idx] = 1'b0;
					brel_n[btn_idx]  = 1'b1;
				end
			end
			ACT_FOCUS_LOST: begin
				held_n  = '0;
				bheld_n = '0;
			end
			ACT_NEW_FRAME: begin
				press_n  = '0;
				rel_n    = '0;
				bpress_n = '0;
				brel_n   = '0;
			end
			default: begin
			end
		endcase
	end

	assign we    = cmd.exec && kok && (act_q == ACT_KEY_DOWN || act_q == ACT_KEY_UP);
	assign wdata = {rel_n, press_n, held_n};

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			act_q <= action;
			key_q <= key_code;
			rep_q <= is_repeat;
			btn_q <= button_code;
			px_q  <= pointer_x;
			py_q  <= pointer_y;
			mdx_q <= move_dx;
			mdy_q <= move_dy;
			wdx_q <= wheel_dx;
			wdy_q <= wheel_dy;
		end
		if (cmd.exec) begin
			flags_q[0] <= kok & held_n[bit_idx];
			flags_q[1] <= kok & press_n[bit_idx];
			flags_q[2] <= kok & rel_n[bit_idx];
			flags_q[3] <= bok & bheld_n[btn_idx];
			flags_q[4] <= bok & bpress_n[btn_idx];
			flags_q[5] <= bok & brel_n[btn_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_vld_q <= '0;
			mark_vld_q <= '0;
			bheld_q    <= '0;
			bpress_q   <= '0;
			brel_q     <= '0;
			pos_x_q    <= '0;
			pos_y_q    <= '0;
			mot_x_q    <= '0;
			mot_y_q    <= '0;
			whl_x_q    <= '0;
			whl_y_q    <= '0;
		end else if (cmd.exec) begin
			bheld_q  <= bheld_n;
			bpress_q <= bpress_n;
			brel_q   <= brel_n;
			if (we) begin
				held_vld_q[row_idx] <= 1'b1;
				mark_vld_q[row_idx] <= 1'b1;
			end
			unique case (act_q) inside
				ACT_BTN_DOWN, ACT_BTN_UP: begin
					pos_x_q <= px_q;
					pos_y_q <= py_q;
				end
				ACT_MOVE: begin
					pos_x_q <= px_q;
					pos_y_q <= py_q;
					mot_x_q <= mot_x_q + {{16{mdx_q[15]}}, mdx_q};
					mot_y_q <= mot_y_q + {{16{mdy_q[15]}}, mdy_q};
				end
				ACT_WHEEL: begin
					whl_x_q <= whl_x_q + {{16{wdx_q[15]}}, wdx_q};
					whl_y_q <= whl_y_q + {{16{wdy_q[15]}}, wdy_q};
				end
				ACT_FOCUS_LOST: begin
					held_vld_q <= '0;
				end
				ACT_NEW_FRAME: begin
					mark_vld_q <= '0;
					mot_x_q    <= '0;
					mot_y_q    <= '0;
					whl_x_q    <= '0;
					whl_y_q    <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	assign key_is_down         = flags_q[0];
	assign key_was_pressed     = flags_q[1];
	assign key_was_released    = flags_q[2];
	assign button_is_down      = flags_q[3];
	assign button_was_pressed  = flags_q[4];
	assign button_was_released = flags_q[5];
	assign mouse_x             = pos_x_q;
	assign mouse_y             = pos_y_q;
	assign motion_x            = mot_x_q;
	assign motion_y            = mot_y_q;
	assign wheel_total_x       = whl_x_q;
	assign wheel_total_y       = whl_y_q;

endmodule
`default_nettype wire

[design/input_event_state_tracker.sv]
`default_nettype none
// Input event tracker. A word is taken at a clock edge where start is high and busy is low;
// busy then stays high for one cycle while the key bitmap row is read from RAM, updated and
// written back, and done pulses high for exactly one cycle in the cycle after that, with
// the result on the output ports. A new word is taken only while busy is low, so the key
// bitmap RAM read-modify-write of one word ends before the next is taken. The receiver cannot
// stall, so done must be sampled in its cycle. Bulk clears (focus lost, new frame) act on
// per-row valid flags, not RAM rows; outputs show the state after the word has been applied.
module input_event_state_tracker
	import iest_pkg::*;
#(
	parameter int NUM_KEYS    = NUM_KEYS_DEF,
	parameter int NUM_BUTTONS = NUM_BUTTONS_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	output logic                  done,
	input  logic [3:0]            action,
	input  logic [KEY_CODE_W-1:0] key_code,
	input  logic                  is_repeat,
	input  logic [BTN_CODE_W-1:0] button_code,
	input  logic signed [15:0]    pointer_x,
	input  logic signed [15:0]    pointer_y,
	input  logic signed [15:0]    move_dx,
	input  logic signed [15:0]    move_dy,
	input  logic signed [15:0]    wheel_dx,
	input  logic signed [15:0]    wheel_dy,
	output logic                  key_is_down,
	output logic                  key_was_pressed,
	output logic                  key_was_released,
	output logic                  button_is_down,
	output logic                  button_was_pressed,
	output logic                  button_was_released,
	output logic signed [15:0]    mouse_x,
	output logic signed [15:0]    mouse_y,
	output logic signed [31:0]    motion_x,
	output logic signed [31:0]    motion_y,
	output logic signed [31:0]    wheel_total_x,
	output logic signed [31:0]    wheel_total_y
);

	iest_cmd_t cmd;

	iest_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.cmd   (cmd)
	);

	iest_dp #(
		.NUM_KEYS   (NUM_KEYS),
		.NUM_BUTTONS(NUM_BUTTONS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.action             (action),
		.key_code           (key_code),
		.is_repeat          (is_repeat),
		.button_code        (button_code),
		.pointer_x          (pointer_x),
		.pointer_y          (pointer_y),
		.move_dx            (move_dx),
		.move_dy            (move_dy),
		.wheel_dx           (wheel_dx),
		.wheel_dy           (wheel_dy),
		.key_is_down        (key_is_down),
		.key_was_pressed    (key_was_pressed),
		.key_was_released   (key_was_released),
		.button_is_down     (button_is_down),
		.button_was_pressed (button_was_pressed),
		.button_was_released(button_was_released),
		.mouse_x            (mouse_x),
		.mouse_y            (mouse_y),
		.motion_x           (motion_x),
		.motion_y           (motion_y),
		.wheel_total_x      (wheel_total_x),
		.wheel_total_y      (wheel_total_y)
	);

endmodule
`default_nettype wire
